FILE: sv/fat_chain_allocator_assert.svh
// Assertion macros used by the checker file.
`ifndef FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FCA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define FCA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: sv/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Types and codes for the allocation table chain manager.
// ----------------------------------------------------------------------------
`default_nettype none
package fca_pkg;
   // table depth and pointer width, fixed by the request and response layout
   localparam int MAX_BLOCKS = 4096;
   localparam int PTR_BITS   = 16;

   typedef enum logic [2:0] {
      MODE_LOAD    = 3'd0,
      MODE_RECOUNT = 3'd1,
      MODE_LOOKUP  = 3'd2,
      MODE_NEW     = 3'd3,
      MODE_EXTEND  = 3'd4,
      MODE_WALK    = 3'd5,
      MODE_FREE    = 3'd6,
      MODE_NONE    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_ENDED   = 2'd2,
      ST_LONG    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,        // issue table read at addr
      S_RDW,       // read data registered
      S_SCAN,      // examine scan entry
      S_LINK,      // write tail link in extend
      S_WEOF,      // write end marker on found block
      S_WALK,      // examine walk entry
      S_FREE,      // examine free entry
      S_DONE
   } state_type;
endpackage
`default_nettype wire

FILE: sv/fat_chain_allocator.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Allocation table of next-block pointers with free count and chain ops.
// ----------------------------------------------------------------------------
// One request at a time through a single-port table memory with registered
// read. Load writes its entry directly; lookup reads, waits for the read data
// and returns it. Recount and allocation scans read, wait and compare each
// entry visited, walk and free read, wait and examine each link followed, and
// each block a walk appends costs a scan plus a link write and an end-marker
// write. A stalled response holds the block. The table is not cleared after
// reset and must be loaded before use.
`default_nettype none
module fat_chain_allocator
   import fca_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] mode, [14:3] block_index, [30:15] entry_value,
   // [42:31] step_count, [43] extend_at_end, [47:44] zero
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] result_block, [28:16] free_blocks, [30:29] status, [31] zero
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_data
);
   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [PTR_BITS-1:0] EOFV = {PTR_BITS{1'b1}};
   localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

   logic [PTR_BITS-1:0] mem [MAX_BLOCKS];
   logic [PTR_BITS-1:0] rd_ff;
   logic                we;
   logic [AW-1:0]       waddr, raddr;
   logic [PTR_BITS-1:0] wdata;
   logic                re;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr];
   end

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [AW-1:0] idx_ff, idx_in, pos_ff, pos_in;
   logic [PTR_BITS-1:0] val_ff, val_in, res_ff, res_in;
   logic [11:0] left_ff, left_in;
   logic ext_ff, ext_in;
   logic [CW-1:0] free_ff, free_in, cnt_ff, cnt_in, lim_ff, lim_in;
   logic [CW:0]   scan_ff, scan_in;
   logic scan_walk_ff, scan_walk_in;
   status_type st_ff, st_in;
   logic [12:0] biu_ff;
   logic [15:0] wpos_ff, wpos_in;
   logic [11:0] sleft_ff, sleft_in;
   logic [15:0] res_out;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);
   assign res_out = 16'(res_ff);
   assign rsp_tdata = {1'b0, st_ff, 13'(free_ff), res_out};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '0;
         biu_ff   <= 13'd4096;
         wpos_ff  <= '0;
         sleft_ff <= '0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         wpos_ff  <= wpos_in;
         sleft_ff <= sleft_in;
         if (csr_valid && csr_ready) biu_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in; idx_ff <= idx_in; pos_ff <= pos_in;
      val_ff <= val_in; res_ff <= res_in; left_ff <= left_in;
      ext_ff <= ext_in; cnt_ff <= cnt_in; lim_ff <= lim_in; scan_ff <= scan_in;
      scan_walk_ff <= scan_walk_in; st_ff <= st_in;
   end

   always_comb begin
      logic [AW-1:0] nx_a;
      logic          in_tab;
      state_in = state_ff; mode_in = mode_ff; idx_in = idx_ff; pos_in = pos_ff;
      val_in = val_ff; res_in = res_ff;
      left_in = left_ff; ext_in = ext_ff; free_in = free_ff; cnt_in = cnt_ff;
      lim_in = lim_ff; scan_in = scan_ff; scan_walk_in = scan_walk_ff;
      st_in = st_ff; wpos_in = wpos_ff; sleft_in = sleft_ff;
      we = 1'b0; waddr = pos_ff; wdata = '0; re = 1'b0; raddr = pos_ff;
      nx_a = AW'(rd_ff);
      in_tab = ({{(32-PTR_BITS){1'b0}}, rd_ff} < 32'(MAX_BLOCKS));
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in = mode_type'(req_tdata[2:0]);
               idx_in  = AW'(32'(req_tdata[14:3]) % MAX_BLOCKS);
               pos_in  = AW'(32'(req_tdata[14:3]) % MAX_BLOCKS);
               val_in  = PTR_BITS'(req_tdata[30:15]);
               left_in = req_tdata[42:31];
               ext_in  = req_tdata[43];
               lim_in  = (32'(biu_ff) > 32'(MAX_BLOCKS)) ? MAXC : CW'(biu_ff);
               res_in  = '0; st_in = ST_OK; cnt_in = '0; scan_in = '0;
               scan_walk_in = 1'b0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            priority case (mode_ff)
               MODE_LOAD: begin
                  we = 1'b1; waddr = idx_ff; wdata = val_ff; res_in = val_ff;
                  state_in = S_DONE;
               end
               MODE_LOOKUP, MODE_WALK, MODE_FREE: begin
                  re = 1'b1; raddr = pos_ff;
                  if (mode_ff == MODE_WALK && left_ff == '0) begin
                     res_in = PTR_BITS'(pos_ff);
                     wpos_in = 16'(pos_ff); sleft_in = '0;
                     state_in = S_DONE;
                  end else state_in = S_RDW;
               end
               MODE_RECOUNT, MODE_NEW, MODE_EXTEND: begin
                  if ((mode_ff != MODE_RECOUNT && free_ff == '0) ||
                      scan_ff >= {1'b0, lim_ff}) begin
                     if (mode_ff == MODE_RECOUNT) free_in = cnt_ff;
                     else begin st_in = ST_NOSPACE; res_in = '0; end
                     state_in = S_DONE;
                  end else begin
                     re = 1'b1; raddr = AW'(scan_ff);
                     state_in = S_RDW;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RDW: begin
            priority case (mode_ff)
               MODE_LOOKUP: begin res_in = rd_ff; state_in = S_DONE; end
               MODE_WALK:   state_in = S_WALK;
               MODE_FREE:   state_in = S_FREE;
               default:     state_in = S_SCAN;
            endcase
         end
         S_SCAN: begin
            if (mode_ff == MODE_RECOUNT) begin
               if (rd_ff == '0) cnt_in = cnt_ff + 1'b1;
               scan_in = scan_ff + 1'b1; state_in = S_RD;
            end else if (rd_ff == '0) begin
               res_in = PTR_BITS'(scan_ff);
               state_in = (mode_ff == MODE_EXTEND) ? S_LINK : S_WEOF;
            end else begin
               scan_in = scan_ff + 1'b1;
               if (scan_ff + 1'b1 >= {1'b0, lim_ff}) begin
                  // out of space
                  if (scan_walk_ff) begin
                     st_in = ST_NOSPACE; res_in = PTR_BITS'(pos_ff);
                     wpos_in = 16'(pos_ff); sleft_in = left_ff;
                     mode_in = MODE_WALK;
                  end else begin
                     st_in = ST_NOSPACE; res_in = '0;
                  end
                  state_in = S_DONE;
               end else state_in = S_RD;
            end
         end
         S_LINK: begin
            we = 1'b1; waddr = scan_walk_ff ? pos_ff : idx_ff; wdata = res_ff;
            state_in = S_WEOF;
         end
         S_WEOF: begin
            we = 1'b1; waddr = AW'(scan_ff); wdata = EOFV;
            free_in = free_ff - 1'b1;
            if (scan_walk_ff) begin
               // continue walk onto the new block
               mode_in = MODE_WALK; scan_walk_in = 1'b0;
               pos_in = AW'(scan_ff); left_in = left_ff - 1'b1;
               state_in = S_RD;
            end else state_in = S_DONE;
         end
         S_WALK: begin
            if (rd_ff == EOFV && !ext_ff) begin
               st_in = ST_ENDED; res_in = PTR_BITS'(pos_ff);
               wpos_in = 16'(pos_ff); sleft_in = left_ff; state_in = S_DONE;
            end else if (rd_ff == EOFV) begin
               if (free_ff == '0 || lim_ff == '0) begin
                  st_in = ST_NOSPACE; res_in = PTR_BITS'(pos_ff);
                  wpos_in = 16'(pos_ff); sleft_in = left_ff; state_in = S_DONE;
               end else begin
                  mode_in = MODE_EXTEND; scan_walk_in = 1'b1; scan_in = '0;
                  state_in = S_RD;
               end
            end else if (!in_tab) begin
               st_in = ST_LONG; res_in = PTR_BITS'(pos_ff);
               wpos_in = 16'(pos_ff); sleft_in = left_ff; state_in = S_DONE;
            end else begin
               pos_in = nx_a; left_in = left_ff - 1'b1; state_in = S_RD;
            end
         end
         S_FREE: begin
            we = 1'b1; waddr = pos_ff; wdata = '0;
            if (free_ff < MAXC) free_in = free_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            res_in = PTR_BITS'(idx_ff);
            if (rd_ff == EOFV) state_in = S_DONE;
            else if (!in_tab || cnt_ff + 1'b1 >= MAXC) begin
               st_in = ST_LONG; state_in = S_DONE;
            end else begin
               pos_in = nx_a; state_in = S_RD;
            end
         end
         S_DONE: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: sv/fca_checker.sv
// ----------------------------------------------------------------------------
// fca_checker
// Port-level checks on the chain manager handshakes and free count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fat_chain_allocator_assert.svh"
module fca_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   `FCA_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_tvalid, !req_tready, "ready while result pending")
   `FCA_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "ready right after request")
   `FCA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `FCA_ASSERT_IMP(a_free_range, clock, reset, rsp_tvalid, rsp_tdata[28:16] <= 13'd4096, "free count out of range")
endmodule
bind fat_chain_allocator fca_checker u_fca_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
